@@ rtl/core/uncommitted_priority_select_top_defines.svh @@
// assertion macros shared by the uncommitted priority select rtl
// no dependencies; taken in by the files that carry assertions
`ifndef UNCOMMITTED_PRIORITY_SELECT_TOP_DEFINES_SVH
`define UNCOMMITTED_PRIORITY_SELECT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UPSEL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UPSEL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/upsel_pkg.sv @@
// types, constants and codes for the uncommitted priority select block
// no dependencies; imported by every module of the block except upsel_ram
`default_nettype none

package upsel_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int PRIO_W     = 32;
    localparam int ADDR_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = 11;
    localparam int USE_W      = (CNT_W > ADDR_W + 1) ? CNT_W : ADDR_W + 1;
    localparam int IDX_W      = 10;
    localparam int OUT_PRIO_W = 32;
    localparam int FUNC_W     = 3;

    localparam logic [PRIO_W-1:0] PRIO_FLOOR = '0;

    localparam logic [FUNC_W-1:0] FUNC_SET_PRIO   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_COMMIT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RD_PRIO    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RD_COMMIT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND       = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [IDX_W-1:0]      node_index;
        logic [OUT_PRIO_W-1:0] priority_value;
        logic                  commit_flag;
    } in_word_t;

    typedef struct packed {
        logic [OUT_PRIO_W-1:0] priority_out;
        logic                  committed_out;
        logic                  found;
        logic [IDX_W-1:0]      found_index;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } upsel_state_t;

    typedef struct packed {
        logic              we_prio;
        logic              we_comm;
        logic [ADDR_W-1:0] addr;
        logic [PRIO_W-1:0] wprio;
        logic              wcomm;
    } ram_ctl_t;

    typedef struct packed {
        logic              init;
        logic              step;
        logic [ADDR_W-1:0] idx;
    } best_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/upsel_ram.sv @@
// generic single-port ram, one write or read a cycle, registered read data
// no dependencies
`default_nettype none

module upsel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/upsel_best.sv @@
// shared compare unit: keeps the best uncommitted priority seen in a scan
// depends on upsel_pkg and the assertion macro header
`default_nettype none
`include "uncommitted_priority_select_top_defines.svh"

module upsel_best
    import upsel_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire best_ctl_t         ctl,
    input  wire logic [PRIO_W-1:0] prio_rdata,
    input  wire logic              comm_rdata,
    output logic      [PRIO_W-1:0] best,
    output logic                   found,
    output logic      [ADDR_W-1:0] best_idx
);

    logic [PRIO_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    always_comb begin
        best_next  = best_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        if (ctl.init) begin
            best_next  = PRIO_FLOOR;
            found_next = 1'b0;
            idx_next   = '0;
        end else if (ctl.step && !comm_rdata && (prio_rdata > best_reg)) begin
            // strict greater: first of equal maxima stays
            best_next  = prio_rdata;
            found_next = 1'b1;
            idx_next   = ctl.idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg  <= PRIO_FLOOR;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            best_reg  <= best_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    assign best     = best_reg;
    assign found    = found_reg;
    assign best_idx = idx_reg;

    `UPSEL_ASSERT_NOW(a_found_nonzero, aclk, aresetn, found_reg,
        best_reg != PRIO_FLOOR, "found entry with minimum priority")
    `UPSEL_ASSERT_NEXT(a_best_monotone, aclk, aresetn, ctl.step && !ctl.init,
        best_reg >= $past(best_reg), "best priority fell during scan")

endmodule

`default_nettype wire

@@ rtl/core/upsel_seq.sv @@
// sequencer: clearing sweep, operation decode and the find scan over the ram
// depends on upsel_pkg and the assertion macro header
`default_nettype none
`include "uncommitted_priority_select_top_defines.svh"

module upsel_seq
    import upsel_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_word_t         s_data,
    input  wire logic [USE_W-1:0] used,
    input  wire logic             out_free,
    output in_word_t              op,
    output logic                  idx_ok,
    output logic                  resp_load,
    output ram_ctl_t              ram_ctl,
    output best_ctl_t             best_ctl
);

    upsel_state_t      state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [USE_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    in_word_t          op_reg, op_next;
    logic              scan_more;

    assign idx_ok    = USE_W'(op_reg.node_index) < used;
    assign scan_more = scan_reg < used;
    assign op        = op_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == ADDR_W'(MAX_NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg.func == FUNC_FIND) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN: begin
                // last pending read is compared on this same edge
                if (!scan_more) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // counters and held word
    always_comb begin
        clr_next      = (state_reg == ST_CLEAR) ? clr_reg + 1'b1 : clr_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        pend_idx_next = ADDR_W'(scan_reg);
        op_next       = (state_reg == ST_IDLE && s_valid) ? s_data : op_reg;
        if (state_reg == ST_EXEC) begin
            scan_next = '0;
        end else if (state_reg == ST_SCAN && scan_more) begin
            scan_next = scan_reg + 1'b1;
            pend_next = 1'b1;
        end
    end

    // outputs
    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        resp_load       = (state_reg == ST_RESP) && out_free;
        ram_ctl.we_prio = 1'b0;
        ram_ctl.we_comm = 1'b0;
        ram_ctl.addr    = ADDR_W'(op_reg.node_index);
        ram_ctl.wprio   = PRIO_W'(op_reg.priority_value);
        ram_ctl.wcomm   = op_reg.commit_flag;
        best_ctl.init   = (state_reg == ST_EXEC);
        best_ctl.step   = pend_reg;
        best_ctl.idx    = pend_idx_reg;
        case (state_reg)
            ST_CLEAR: begin
                ram_ctl.we_prio = 1'b1;
                ram_ctl.we_comm = 1'b1;
                ram_ctl.addr    = clr_reg;
                ram_ctl.wprio   = PRIO_FLOOR;
                ram_ctl.wcomm   = 1'b0;
            end
            ST_EXEC: begin
                case (op_reg.func)
                    FUNC_SET_PRIO:   ram_ctl.we_prio = idx_ok;
                    FUNC_SET_COMMIT: ram_ctl.we_comm = idx_ok;
                    default:         ram_ctl.we_prio = 1'b0;
                endcase
            end
            ST_SCAN: begin
                ram_ctl.addr = ADDR_W'(scan_reg);
            end
            default: ram_ctl.addr = ADDR_W'(op_reg.node_index);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        op_reg       <= op_next;
    end

    `UPSEL_ASSERT_NOW(a_write_in_range, aclk, aresetn,
        (ram_ctl.we_prio || ram_ctl.we_comm) && state_reg != ST_CLEAR, idx_ok,
        "write to entry outside node count")
    `UPSEL_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready,
        "second word taken while busy")
    `UPSEL_ASSERT_NOW(a_step_in_scan, aclk, aresetn, pend_reg,
        state_reg == ST_SCAN || state_reg == ST_RESP, "compare step outside a find")

endmodule

`default_nettype wire

@@ rtl/core/uncommitted_priority_select_top.sv @@
// Table of per-node priorities and committed marks with a find-best scan.
// After reset the block sweeps all MAX_NODES (1024) entries to zero, one a
// cycle, and holds s_ready low throughout the sweep. Each word is then taken
// only while the block is idle. Writes and reads pass through the exec and
// resp states; find adds a scan over the entries in use (node count capped
// at 1024) between them, paced by one read a cycle from the single-port
// table feeding one shared comparator. A finished result waits in an output
// register while the next word is accepted. The node count register is
// written through cfg_* at any time (cfg_ready is always high) but should
// change only while idle.
// Depends on upsel_pkg, upsel_seq, upsel_best, upsel_ram.
`default_nettype none
`include "uncommitted_priority_select_top_defines.svh"

module uncommitted_priority_select_top
    import upsel_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_word_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_word_t             m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    logic [CNT_W-1:0]  node_count_reg;
    logic [USE_W-1:0]  used;
    logic              m_valid_reg, m_valid_next;
    out_word_t         out_reg, res;
    logic              out_free;
    in_word_t          op;
    logic              idx_ok;
    logic              resp_load;
    ram_ctl_t          ram_ctl;
    best_ctl_t         best_ctl;
    logic [PRIO_W-1:0] prio_rdata;
    logic              comm_rdata;
    logic [PRIO_W-1:0] best;
    logic              found;
    logic [ADDR_W-1:0] best_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (cfg_valid) begin
            node_count_reg <= cfg_data;
        end
    end

    // entries in use, capped at the table size
    assign used = (USE_W'(node_count_reg) > USE_W'(MAX_NODES)) ?
                  USE_W'(MAX_NODES) : USE_W'(node_count_reg);

    assign out_free = !m_valid_reg || m_ready;

    upsel_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .used      (used),
        .out_free  (out_free),
        .op        (op),
        .idx_ok    (idx_ok),
        .resp_load (resp_load),
        .ram_ctl   (ram_ctl),
        .best_ctl  (best_ctl)
    );

    upsel_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (MAX_NODES)
    ) u_prio_ram (
        .aclk  (aclk),
        .we    (ram_ctl.we_prio),
        .addr  (ram_ctl.addr),
        .wdata (ram_ctl.wprio),
        .rdata (prio_rdata)
    );

    upsel_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NODES)
    ) u_comm_ram (
        .aclk  (aclk),
        .we    (ram_ctl.we_comm),
        .addr  (ram_ctl.addr),
        .wdata (ram_ctl.wcomm),
        .rdata (comm_rdata)
    );

    upsel_best u_best (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (best_ctl),
        .prio_rdata (prio_rdata),
        .comm_rdata (comm_rdata),
        .best       (best),
        .found      (found),
        .best_idx   (best_idx)
    );

    // result word from the held operation; ram data is stable while in resp
    always_comb begin
        res = '0;
        case (op.func)
            FUNC_RD_PRIO: begin
                res.priority_out = idx_ok ? OUT_PRIO_W'(prio_rdata) : '0;
            end
            FUNC_RD_COMMIT: begin
                res.committed_out = idx_ok & comm_rdata;
            end
            FUNC_FIND: begin
                res.priority_out = found ? OUT_PRIO_W'(best) : '0;
                res.found        = found;
                res.found_index  = found ? IDX_W'(best_idx) : '0;
            end
            default: res = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (resp_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_load) begin
            out_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `UPSEL_ASSERT_NEXT(a_result_shown, aclk, aresetn, resp_load, m_valid,
        "result word not presented after load")
    `UPSEL_ASSERT_NOW(a_load_when_free, aclk, aresetn, resp_load, !m_valid_reg || m_ready,
        "result word overwritten before taken")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for uncommitted_priority_select_top
// depends on upsel_pkg and the block's rtl; a directed table then random words
`timescale 1ns / 1ps

module testbench;
    import upsel_pkg::*;

    localparam int TIMEOUT_NS    = 25_000_000;
    localparam int SETTLE_CYCLES = MAX_NODES + 64;
    localparam int MAX_REPORTS   = 40;
    localparam int N_PHASES      = 9;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_C = 3'd7;

    localparam out_word_t ZERO_RESULT = '0;

    // random phases: node count, words, sender idle %, receiver idle %
    localparam int PHASE_COUNT [N_PHASES] = '{8, 1, 1024, 0, 3, 2047, 31, 16, 1024};
    localparam int PHASE_WORDS [N_PHASES] = '{110, 40, 30, 20, 70, 40, 120, 110, 40};
    localparam int PHASE_SRC   [N_PHASES] = '{36, 36, 36, 36, 48, 48, 48, 0, 0};
    localparam int PHASE_SNK   [N_PHASES] = '{48, 48, 48, 48, 36, 36, 36, 0, 0};

    typedef enum bit {ROW_WORD, ROW_COUNT} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        in_word_t         word;
        bit               pinned;
        out_word_t        result;
        logic [CNT_W-1:0] count;
    } dir_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_word_t         s_data;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_word_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // typed-in expectation travels with the word it belongs to
    logic      pin_use;
    out_word_t pin_word;

    // mirror of the block's table and node count
    bit [PRIO_W-1:0]  prio_mirror   [MAX_NODES];
    bit               commit_mirror [MAX_NODES];
    logic [CNT_W-1:0] count_mirror = '0;

    out_word_t pending_results [$];
    dir_row_t  dir_rows [$];

    int src_idle_pct = 36;
    int snk_idle_pct = 48;
    int error_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int finds_checked = 0;
    int settings_seen = 1;

    uncommitted_priority_select_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // applies one word to the mirror and returns the result it should give
    function automatic out_word_t table_op(input in_word_t w);
        out_word_t   r;
        int unsigned used;
        int unsigned i;
        logic        in_use;
        logic [PRIO_W-1:0] best;
        r = '0;
        used = (count_mirror > MAX_NODES) ? MAX_NODES : count_mirror;
        in_use = (w.node_index < used);
        case (w.func)
            FUNC_SET_PRIO: begin
                if (in_use) prio_mirror[w.node_index] = w.priority_value;
            end
            FUNC_SET_COMMIT: begin
                if (in_use) commit_mirror[w.node_index] = w.commit_flag;
            end
            FUNC_RD_PRIO: begin
                r.priority_out = in_use ? prio_mirror[w.node_index] : PRIO_FLOOR;
            end
            FUNC_RD_COMMIT: begin
                r.committed_out = in_use ? commit_mirror[w.node_index] : 1'b0;
            end
            FUNC_FIND: begin
                // strictly greater keeps the first of equal maxima
                best = PRIO_FLOOR;
                for (i = 0; i < used; i++) begin
                    if (!commit_mirror[i] && prio_mirror[i] > best) begin
                        best = prio_mirror[i];
                        r.found = 1'b1;
                        r.found_index = IDX_W'(i);
                    end
                end
                if (r.found) r.priority_out = best;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic in_word_t random_word(input int unsigned used);
        in_word_t    w;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35) w.func = FUNC_SET_PRIO;
        else if (pick < 55) w.func = FUNC_SET_COMMIT;
        else if (pick < 70) w.func = FUNC_RD_PRIO;
        else if (pick < 80) w.func = FUNC_RD_COMMIT;
        else if (pick < 95) w.func = FUNC_FIND;
        else w.func = FUNC_UNUSED_A + FUNC_W'($urandom_range(2));
        // mostly entries in use, now and then anywhere
        if (used != 0 && $urandom_range(99) < 85)
            w.node_index = IDX_W'($urandom_range(used - 1));
        else w.node_index = IDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 50) w.priority_value = $urandom;
        else if (pick < 75) w.priority_value = $urandom_range(7);
        else if (pick < 90) w.priority_value = 32'hFFFF_FFFF - $urandom_range(3);
        else w.priority_value = PRIO_FLOOR;
        w.commit_flag = ($urandom_range(99) < 40);
        return w;
    endfunction

    function automatic void add_word(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                                     input logic [OUT_PRIO_W-1:0] prio, input logic flag,
                                     input bit pinned, input out_word_t res);
        dir_row_t row;
        row.kind = ROW_WORD;
        row.word = '{func: f, node_index: idx, priority_value: prio, commit_flag: flag};
        row.pinned = pinned;
        row.result = res;
        row.count = '0;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void add_count(input logic [CNT_W-1:0] count);
        dir_row_t row;
        row.kind = ROW_COUNT;
        row.word = '0;
        row.pinned = 1'b0;
        row.result = ZERO_RESULT;
        row.count = count;
        dir_rows = {dir_rows, row};
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    task automatic send_word(input in_word_t w, input bit pinned, input out_word_t res);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_data   <= w;
        pin_use  <= pinned;
        pin_word <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] count);
        wait_for_results();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        settings_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // mirror update on accepted words, comparison on accepted results
    always @(posedge aclk) begin : scoreboard
        out_word_t predicted;
        out_word_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) count_mirror = cfg_data;
            if (s_valid && s_ready) begin
                predicted = table_op(s_data);
                pending_results = {pending_results, (pin_use ? pin_word : predicted)};
                words_sent++;
                if (s_data.func == FUNC_FIND) finds_checked++;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("result word 0x%0h arrived with nothing expected", m_data);
                end else begin
                    want = pending_results.pop_front();
                    check_field("priority_out", want.priority_out, m_data.priority_out);
                    check_field("committed_out", 32'(want.committed_out),
                                32'(m_data.committed_out));
                    check_field("found", 32'(want.found), 32'(m_data.found));
                    check_field("found_index", 32'(want.found_index), 32'(m_data.found_index));
                    results_checked++;
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        int p;
        int k;
        int unsigned used;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        pin_use   = 1'b0;
        pin_word  = '0;

        // node count still at its reset value of zero
        add_word(FUNC_FIND,       10'd0,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_RD_PRIO,    10'd0,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_SET_PRIO,   10'd0,    32'hFFFF_FFFF, 1'b0, 1, ZERO_RESULT);
        add_count(11'd4);
        add_word(FUNC_RD_PRIO,    10'd0,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_RD_COMMIT,  10'd3,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_FIND,       10'd0,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_SET_PRIO,   10'd0,    32'hFFFF_FFFF, 1'b0, 1, ZERO_RESULT);
        add_word(FUNC_SET_PRIO,   10'd3,    32'hFFFF_FFFF, 1'b1, 1, ZERO_RESULT);
        add_word(FUNC_RD_PRIO,    10'd0,    32'h0,         1'b0, 1,
                 out_word_t'{32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0});
        add_word(FUNC_FIND,       10'd0,    32'h0,         1'b0, 1,
                 out_word_t'{32'hFFFF_FFFF, 1'b0, 1'b1, 10'd0});
        add_word(FUNC_SET_COMMIT, 10'd0,    32'h0,         1'b1, 1, ZERO_RESULT);
        add_word(FUNC_RD_COMMIT,  10'd0,    32'h0,         1'b0, 1,
                 out_word_t'{32'h0, 1'b1, 1'b0, 10'd0});
        add_word(FUNC_FIND,       10'd0,    32'h0,         1'b0, 1,
                 out_word_t'{32'hFFFF_FFFF, 1'b0, 1'b1, 10'd3});
        add_word(FUNC_SET_PRIO,   10'd4,    32'd5,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_RD_PRIO,    10'd4,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_UNUSED_A,   10'd1,    32'hA5A5_A5A5, 1'b1, 1, ZERO_RESULT);
        add_word(FUNC_UNUSED_B,   10'd2,    32'h5A5A_5A5A, 1'b0, 1, ZERO_RESULT);
        add_word(FUNC_UNUSED_C,   10'h3FF,  32'hFFFF_FFFF, 1'b1, 1, ZERO_RESULT);
        add_word(FUNC_SET_COMMIT, 10'd3,    32'h0,         1'b1, 1, ZERO_RESULT);
        add_word(FUNC_FIND,       10'd0,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_SET_PRIO,   10'd2,    32'd1,         1'b0, 0, ZERO_RESULT);
        add_word(FUNC_SET_COMMIT, 10'd0,    32'h0,         1'b0, 1, ZERO_RESULT);
        add_word(FUNC_FIND,       10'd0,    32'h0,         1'b0, 0, ZERO_RESULT);
        // count beyond the table clips to the full table
        add_count(11'd2047);
        add_word(FUNC_SET_PRIO,   10'h3FF,  32'h8000_0000, 1'b0, 1, ZERO_RESULT);
        add_word(FUNC_RD_PRIO,    10'h3FF,  32'h0,         1'b0, 0, ZERO_RESULT);
        add_word(FUNC_FIND,       10'd0,    32'h0,         1'b0, 0, ZERO_RESULT);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        // ready stays low through the clearing sweep
        while (!s_ready) @(posedge aclk);

        for (r = 0; r < dir_rows.size(); r++) begin
            if (dir_rows[r].kind == ROW_COUNT) begin
                write_node_count(dir_rows[r].count);
            end else begin
                send_word(dir_rows[r].word, dir_rows[r].pinned, dir_rows[r].result);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            write_node_count(CNT_W'(PHASE_COUNT[p]));
            src_idle_pct = PHASE_SRC[p];
            snk_idle_pct = PHASE_SNK[p];
            used = (PHASE_COUNT[p] > MAX_NODES) ? MAX_NODES : PHASE_COUNT[p];
            for (k = 0; k < PHASE_WORDS[p]; k++) begin
                // sender holds off mid-phase until the block has emptied
                if (k == PHASE_WORDS[p] / 2) wait_for_results();
                send_word(random_word(used), 1'b0, ZERO_RESULT);
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d words sent, %0d results checked, %0d of them finds",
                 words_sent, results_checked, finds_checked);
        $display("%0d node count settings including 0, 1024 and 2047", settings_seen);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
